### hw/rtl/pli_pkg.sv
// Package for the piecewise-linear interpolator: field widths, table entry type,
// result codes and controller states. No dependencies.
package pli_pkg;

   localparam int X_W    = 16;
   localparam int Y_W    = 24;
   localparam int IDX_W  = 5;
   localparam int CNT_W  = 6;
   localparam int CODE_W = 3;
   localparam int PROD_W = X_W + Y_W;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CODE_W-1:0] CODE_INTERIOR = 3'd0;
   localparam logic [CODE_W-1:0] CODE_BELOW    = 3'd1;
   localparam logic [CODE_W-1:0] CODE_ABOVE    = 3'd2;
   localparam logic [CODE_W-1:0] CODE_NONE     = 3'd3;
   localparam logic [CODE_W-1:0] CODE_WRITE    = 3'd4;

   typedef struct packed {
      logic signed [X_W-1:0] x;
      logic signed [Y_W-1:0] y;
   } pli_point_type;

   typedef struct packed {
      logic busy;
      logic done;
   } pli_div_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_READ_FIRST,
      ST_READ_LAST,
      ST_SCAN,
      ST_MULT,
      ST_DIV_LOAD,
      ST_DIV_WAIT,
      ST_DONE
   } pli_state_type;

endpackage

### hw/rtl/pli_table.sv
// Breakpoint table: one write port, one read port, registered read data.
// Depends on pli_pkg.
module pli_table #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  pli_pkg::pli_point_type wr_data,
   input  logic [AW-1:0]         rd_addr,
   output pli_pkg::pli_point_type rd_data
);
   import pli_pkg::*;

   pli_point_type mem [DEPTH];
   pli_point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/pli_divider.sv
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in Y_W bits, so only that many steps run. Depends on pli_pkg.
module pli_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pli_pkg::PROD_W-1:0]    dividend,
   input  logic [pli_pkg::X_W-1:0]       divisor,
   output logic [pli_pkg::Y_W-1:0]       quotient,
   output pli_pkg::pli_div_status_type   status
);
   import pli_pkg::*;

   localparam int STEP_W = $clog2(Y_W + 1);

   logic [X_W-1:0]    rem_ff, rem_in;
   logic [Y_W-1:0]    low_ff, low_in;
   logic [X_W-1:0]    dvs_ff, dvs_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [X_W:0]      trial;

   always_comb begin
      rem_in   = rem_ff;
      low_in   = low_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, low_ff[Y_W-1]} - {1'b0, dvs_ff};
      if (start) begin
         // remainder starts below the divisor since the quotient fits Y_W bits
         rem_in   = dividend[PROD_W-1:Y_W];
         low_in   = dividend[Y_W-1:0];
         dvs_in   = divisor;
         count_in = STEP_W'(Y_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!trial[X_W]) begin
            rem_in = trial[X_W-1:0];
            low_in = {low_ff[Y_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[X_W-2:0], low_ff[Y_W-1]};
            low_in = {low_ff[Y_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = low_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

### hw/rtl/piecewise_linear_interpolator.sv
// Piecewise-linear interpolator, top level. Depends on pli_pkg, pli_table, pli_divider.
//
// Breakpoints (x in Q1.15, y in Q16.8) are loaded one per request with opcode
// write; csr_wr_data sets how many entries, from index 0 up, form the curve
// (values above MAX_POINTS count as MAX_POINTS). A query request returns the
// ordinate at req_query_x: the end ordinates outside the table, otherwise
// y_i + (x - x_i)(y_i+1 - y_i)/(x_i+1 - x_i) on the first segment holding x,
// truncated toward zero, with rsp_case_code telling which case applied.
// Entries are held in a single-port-read table with registered read data, so
// the segment search reads one breakpoint per cycle; the quotient comes from a
// bit-serial divider. One request is in work at a time: a write goes straight
// to its response, a query on an empty table reads no entry, one that clamps
// reads the first and last entries, and one that interpolates also scans the
// segments, then multiplies and runs the divider.
// A finished response waits in an output register so the next request is
// taken meanwhile. The table has no reset; querying entries never written
// gives unspecified values.
module piecewise_linear_interpolator #(
   parameter int MAX_POINTS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic [pli_pkg::IDX_W-1:0]          req_point_index,
   input  logic signed [pli_pkg::X_W-1:0]     req_point_x,
   input  logic signed [pli_pkg::Y_W-1:0]     req_point_y,
   input  logic signed [pli_pkg::X_W-1:0]     req_query_x,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [pli_pkg::Y_W-1:0]     rsp_value,
   output logic [pli_pkg::CODE_W-1:0]         rsp_case_code,
   input  logic                               csr_wr_en,
   input  logic [pli_pkg::CNT_W-1:0]          csr_wr_data
);
   import pli_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   pli_state_type state_ff, state_in;

   logic [CNT_W-1:0]      point_count_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [Y_W-1:0] rsp_value_ff, rsp_value_in;
   logic [CODE_W-1:0]     rsp_code_ff, rsp_code_in;

   // result waiting for the output register
   logic signed [Y_W-1:0] res_value_ff, res_value_in;
   logic [CODE_W-1:0]     res_code_ff, res_code_in;

   logic signed [X_W-1:0] qx_ff, qx_in;       // query abscissa
   pli_point_type         prev_ff, prev_in;   // entry before the one being read
   logic [AW-1:0]         idx_ff, idx_in;     // index of the entry on rd_data
   logic [X_W-1:0]        dx_ff, dx_in;       // segment width
   logic [X_W-1:0]        dxq_ff, dxq_in;     // offset of query into segment
   logic signed [Y_W:0]   dy_ff, dy_in;       // segment rise
   logic signed [Y_W-1:0] y0_ff, y0_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;   // |offset * rise|
   logic                  neg_ff, neg_in;

   logic [CW-1:0]         n_used;
   logic [AW-1:0]         last_idx;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   pli_point_type         wr_data;
   logic [AW-1:0]         rd_addr;
   pli_point_type         rd_data;

   logic                  div_start;
   logic [Y_W-1:0]        div_quotient;
   pli_div_status_type    div_status;

   logic signed [X_W:0]   seg_dx;
   logic signed [X_W:0]   seg_dxq;
   logic signed [Y_W:0]   seg_dy;
   logic [Y_W:0]          dy_mag;
   logic signed [Y_W:0]   q_signed;
   logic signed [Y_W:0]   interp_sum;
   logic                  req_fire;

   assign n_used   = (32'(point_count_ff) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                         : CW'(point_count_ff);
   assign last_idx = AW'(n_used - CW'(1));
   assign req_fire = req_valid && req_ready;

   // write port: the breakpoint lands in the table the cycle it is accepted
   assign wr_en   = req_fire && (req_opcode == OP_WRITE)
                    && (32'(req_point_index) < MAX_POINTS);
   assign wr_addr = AW'(req_point_index);
   assign wr_data = '{x: req_point_x, y: req_point_y};

   // segment arithmetic on the previous and current entries during the scan
   assign seg_dx  = {rd_data.x[X_W-1], rd_data.x} - {prev_ff.x[X_W-1], prev_ff.x};
   assign seg_dxq = {qx_ff[X_W-1], qx_ff} - {prev_ff.x[X_W-1], prev_ff.x};
   assign seg_dy  = {rd_data.y[Y_W-1], rd_data.y} - {prev_ff.y[Y_W-1], prev_ff.y};

   assign dy_mag     = dy_ff[Y_W] ? (Y_W+1)'(-dy_ff) : (Y_W+1)'(dy_ff);
   assign q_signed   = neg_ff ? -$signed({1'b0, div_quotient})
                              : $signed({1'b0, div_quotient});
   assign interp_sum = {y0_ff[Y_W-1], y0_ff} + q_signed;

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      rd_addr      = '0;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_code_in  = rsp_code_ff;
      res_value_in = res_value_ff;
      res_code_in  = res_code_ff;
      qx_in        = qx_ff;
      prev_in      = prev_ff;
      idx_in       = idx_ff;
      dx_in        = dx_ff;
      dxq_in       = dxq_ff;
      dy_in        = dy_ff;
      y0_in        = y0_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               qx_in = req_query_x;
               if (req_opcode == OP_WRITE) begin
                  res_value_in = '0;
                  res_code_in  = CODE_WRITE;
                  state_in     = ST_DONE;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            if (n_used == '0) begin
               res_value_in = '0;
               res_code_in  = CODE_NONE;
               state_in     = ST_DONE;
            end else begin
               rd_addr  = '0;
               state_in = ST_READ_FIRST;
            end
         end
         ST_READ_FIRST: begin
            // first entry on rd_data; fetch the last one
            prev_in  = rd_data;
            rd_addr  = last_idx;
            state_in = ST_READ_LAST;
         end
         ST_READ_LAST: begin
            if (qx_ff <= prev_ff.x) begin
               res_value_in = prev_ff.y;
               res_code_in  = CODE_BELOW;
               state_in     = ST_DONE;
            end else if (qx_ff >= rd_data.x) begin
               res_value_in = rd_data.y;
               res_code_in  = CODE_ABOVE;
               state_in     = ST_DONE;
            end else begin
               // at least two points here, entry 1 exists
               rd_addr  = AW'(1);
               idx_in   = AW'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((qx_ff >= prev_ff.x) && (qx_ff <= rd_data.x)) begin
               // match implies 0 <= offset <= width <= 65535
               dx_in    = seg_dx[X_W-1:0];
               dxq_in   = seg_dxq[X_W-1:0];
               dy_in    = seg_dy;
               y0_in    = prev_ff.y;
               state_in = ST_MULT;
            end else if (idx_ff == last_idx) begin
               res_value_in = '0;
               res_code_in  = CODE_NONE;
               state_in     = ST_DONE;
            end else begin
               prev_in  = rd_data;
               idx_in   = AW'(idx_ff + 1'b1);
               rd_addr  = AW'(idx_ff + 1'b1);
            end
         end
         ST_MULT: begin
            if (dx_ff == '0) begin
               // zero-width segment
               res_value_in = y0_ff;
               res_code_in  = CODE_INTERIOR;
               state_in     = ST_DONE;
            end else begin
               prod_in  = PROD_W'(dxq_ff) * PROD_W'(dy_mag[Y_W-1:0]);
               neg_in   = dy_ff[Y_W];
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               res_value_in = interp_sum[Y_W-1:0];
               res_code_in  = CODE_INTERIOR;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_code_in  = res_code_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         point_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            point_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_code_ff  <= rsp_code_in;
      res_value_ff <= res_value_in;
      res_code_ff  <= res_code_in;
      qx_ff        <= qx_in;
      prev_ff      <= prev_in;
      idx_ff       <= idx_in;
      dx_ff        <= dx_in;
      dxq_ff       <= dxq_in;
      dy_ff        <= dy_in;
      y0_ff        <= y0_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
   end

   pli_table #(
      .DEPTH (MAX_POINTS),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pli_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (dx_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_case_code = rsp_code_ff;

endmodule

### bench/piecewise_linear_interpolator_test.sv
// Testbench for piecewise_linear_interpolator: loads breakpoint tables, queries the curve
// and compares every response against an in-bench interpolation of the same table.
// Depends on pli_pkg and the piecewise_linear_interpolator RTL.
module piecewise_linear_interpolator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pli_pkg::*;

   localparam int MAX_PTS        = 32;
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side
   localparam int RANDOM_ITEMS   = 600;
   localparam int SETTLE_CYCLES  = 80;    // settling time after the final drain

   typedef struct {
      logic signed [Y_W-1:0] value;
      logic [CODE_W-1:0]     code;
   } curve_answer_type;

   // ---------------------------------------------------------------- DUT ports
   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_opcode = OP_WRITE;
   logic [IDX_W-1:0]      req_point_index = '0;
   logic signed [X_W-1:0] req_point_x = '0;
   logic signed [Y_W-1:0] req_point_y = '0;
   logic signed [X_W-1:0] req_query_x = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic signed [Y_W-1:0] rsp_value;
   logic [CODE_W-1:0]     rsp_case_code;
   logic                  csr_wr_en = 1'b0;
   logic [CNT_W-1:0]      csr_wr_data = '0;

   // ---------------------------------------------------------------- bench state
   // Mirror of the breakpoint table and the point count register.
   logic signed [X_W-1:0] curve_x [MAX_PTS];
   logic signed [Y_W-1:0] curve_y [MAX_PTS];
   logic [CNT_W-1:0]      curve_length = '0;

   curve_answer_type pending_answers [$];   // one entry per accepted request, oldest first
   curve_answer_type head_answer;
   int            mismatch_count = 0;
   int            requests_sent = 0;
   int            stall_left = 0;
   int            quiet_cycles = 0;
   bit            no_idle = 1'b0;        // burst stretches: no gaps on either side

   piecewise_linear_interpolator #(
      .MAX_POINTS(MAX_PTS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_point_index(req_point_index),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_query_x    (req_query_x),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_case_code  (rsp_case_code),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction
   // Counts above the table size clamp to the table size.
   function automatic int points_in_use();
      return (curve_length > MAX_PTS) ? MAX_PTS : int'(curve_length);
   endfunction

   // Applies one request to the mirrored table and returns the response it must give.
   function automatic curve_answer_type interpolate_curve(
      input logic op, input logic [IDX_W-1:0] idx, input logic signed [X_W-1:0] px,
      input logic signed [Y_W-1:0] py, input logic signed [X_W-1:0] qx);
      curve_answer_type ans;
      int            n;
      int            i;
      longint        x0, x1, y0, y1, span, r;
      ans.value = '0;
      ans.code  = CODE_NONE;
      if (op == OP_WRITE) begin
         curve_x[idx] = px;
         curve_y[idx] = py;
         ans.code = CODE_WRITE;
         return ans;
      end
      n = points_in_use();
      if (n == 0) return ans;
      // clamp at either end; the low end wins when both apply (single point)
      if (qx <= curve_x[0]) begin
         ans.value = curve_y[0];
         ans.code  = CODE_BELOW;
         return ans;
      end
      if (qx >= curve_x[n-1]) begin
         ans.value = curve_y[n-1];
         ans.code  = CODE_ABOVE;
         return ans;
      end
      // first segment that holds x; a zero-width one yields its left ordinate
      for (i = 0; i + 1 < n; i++) begin
         if (qx >= curve_x[i] && qx <= curve_x[i+1]) begin
            x0 = curve_x[i];
            x1 = curve_x[i+1];
            y0 = curve_y[i];
            y1 = curve_y[i+1];
            span = x1 - x0;
            r = y0;
            if (span > 0) r = y0 + ((longint'(qx) - x0) * (y1 - y0)) / span;
            ans.value = Y_W'(r);
            ans.code  = CODE_INTERIOR;
            return ans;
         end
      end
      return ans;   // no segment: non-ascending table
   endfunction

   // ---------------------------------------------------------------- idling
   // Mostly back-to-back or short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Response side back-pressure.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < 200)
         $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("response with no request outstanding", rsp_value, 0);
         end else begin
            head_answer = pending_answers.pop_front();
            if (rsp_value !== head_answer.value)
               report_mismatch("rsp_value", rsp_value, head_answer.value);
            if (rsp_case_code !== head_answer.code)
               report_mismatch("rsp_case_code", rsp_case_code, head_answer.code);
         end
      end
   end

   // Ends a hung run: counts cycles in which neither channel completes a handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("[piecewise_linear_interpolator] ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- request driving
   // Holds valid until the block takes the request, then records the expected response.
   // Valid is left high on return; the next send or a drain decides what happens to it.
   task automatic send_request(
      input logic op, input logic [IDX_W-1:0] idx, input logic signed [X_W-1:0] px,
      input logic signed [Y_W-1:0] py, input logic signed [X_W-1:0] qx);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_point_index <= idx;
      req_point_x     <= px;
      req_point_y     <= py;
      req_query_x     <= qx;
      do @(posedge clock); while (!req_ready);
      pending_answers.push_back(interpolate_curve(op, idx, px, py, qx));
      requests_sent++;
   endtask

   // Unused fields carry random noise; the block must ignore them.
   task automatic write_point(input int idx, input int x, input int y);
      send_request(OP_WRITE, IDX_W'(idx), X_W'(x), Y_W'(y), X_W'($urandom));
   endtask

   task automatic query_at(input int x);
      send_request(OP_QUERY, IDX_W'($urandom), X_W'($urandom), Y_W'($urandom), X_W'(x));
   endtask

   // Waits until every response is back; with one request in work at a time the
   // block is idle from then on.
   task automatic drain_answers();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic set_point_count(input int count);
      drain_answers();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CNT_W'(count);
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      curve_length = CNT_W'(count);
   endtask

   function automatic int random_ordinate();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return -8388608;
      if (roll == 1) return 8388607;
      return int'($urandom);
   endfunction

   // Writes entries 0..m-1 with ascending (possibly repeated) abscissae.
   task automatic load_sorted_curve(input int m);
      int cur;
      int j;
      cur = ($urandom_range(0, 7) == 0) ? -32768 : -32768 + int'($urandom_range(0, 32767));
      for (j = 0; j < m; j++) begin
         if (j > 0) cur = cur + int'($urandom_range(0, (32767 - cur) / (m - j)));
         write_point(j, cur, random_ordinate());
      end
   endtask

   // Mostly inside the curve, some exactly on breakpoints, the rest anywhere.
   task automatic query_on_curve();
      int n;
      int lo;
      int hi;
      int roll;
      n = points_in_use();
      roll = $urandom_range(0, 99);
      if (n == 0) begin
         query_at(int'($urandom));
      end else begin
         lo = curve_x[0];
         hi = curve_x[n-1];
         if (roll < 65 && hi > lo) query_at(lo + int'($urandom_range(0, hi - lo)));
         else if (roll < 80) query_at(curve_x[$urandom_range(0, n - 1)]);
         else query_at(int'($urandom));
      end
   endtask

   // ---------------------------------------------------------------- tests
   // Nothing in the table yet; count zero must answer code none whatever x is.
   task automatic test_empty_table();
      set_point_count(0);
      query_at(-32768);
      query_at(32767);
      query_at(0);
   endtask

   // One breakpoint: below or at it clamps low, above it clamps high.
   task automatic test_single_point();
      write_point(0, -32768, 8388607);
      set_point_count(1);
      query_at(-32768);
      query_at(32767);
      write_point(0, 0, -8388608);
      query_at(0);
      query_at(1);
   endtask

   // Widest possible segment with full-scale rise, then full-scale fall.
   task automatic test_extreme_slope();
      write_point(0, -32768, -8388608);
      write_point(1, 32767, 8388607);
      set_point_count(2);
      query_at(-32767);
      query_at(-1);
      query_at(32766);
      query_at(32767);
      write_point(0, -32768, 8388607);
      write_point(1, 32767, -8388608);
      query_at(1);
      query_at(32766);
   endtask

   // Repeated abscissa and a step backwards: first matching segment must win.
   task automatic test_irregular_table();
      write_point(2, 100, -5000);
      write_point(3, -50, 77777);
      write_point(4, 300, -123);
      write_point(0, -100, 2560);
      write_point(1, 100, -700);
      set_point_count(5);
      query_at(-100);
      query_at(0);
      query_at(100);
      query_at(200);
      query_at(300);
   endtask

   // Fills all entries, then counts at and above the table size.
   task automatic test_full_table();
      load_sorted_curve(MAX_PTS);
      set_point_count(63);
      repeat (8) query_on_curve();
      set_point_count(MAX_PTS);
      repeat (8) query_on_curve();
      set_point_count($urandom_range(MAX_PTS + 1, 62));
      repeat (8) query_on_curve();
   endtask

   // Random curves; every entry is written by now, so any count is safe.
   task automatic test_random_curves();
      int goal;
      int m;
      goal = requests_sent + RANDOM_ITEMS;
      while (requests_sent < goal) begin
         no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) != 0) begin
            // well-formed: a fresh ascending curve, mostly small
            m = ($urandom_range(0, 7) == 0) ? $urandom_range(9, MAX_PTS) : $urandom_range(1, 8);
            load_sorted_curve(m);
            if (m == MAX_PTS && $urandom_range(0, 1) == 1)
               set_point_count($urandom_range(MAX_PTS, 63));
            else
               set_point_count(m);
            repeat ($urandom_range(8, 24)) query_on_curve();
         end else begin
            // broken: stray writes anywhere mixed with queries, any count
            set_point_count($urandom_range(0, 63));
            repeat ($urandom_range(8, 24)) begin
               if ($urandom_range(0, 2) == 0)
                  write_point($urandom_range(0, MAX_PTS - 1), int'($urandom), random_ordinate());
               else
                  query_on_curve();
            end
         end
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_single_point();
      test_extreme_slope();
      test_irregular_table();
      test_full_table();
      test_random_curves();
      drain_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("[piecewise_linear_interpolator] OK");
      end else begin
         $display("[piecewise_linear_interpolator] ERROR");
      end
      $finish;
   end

endmodule

### piecewise_linear_interpolator.f
hw/rtl/pli_pkg.sv
hw/rtl/pli_table.sv
hw/rtl/pli_divider.sv
hw/rtl/piecewise_linear_interpolator.sv
bench/piecewise_linear_interpolator_test.sv
